### design/causal_depthwise_conv_stream_core_macros.svh
// Assertion macros shared by the convolution core RTL
`ifndef CAUSAL_DEPTHWISE_CONV_STREAM_CORE_MACROS_SVH
`define CAUSAL_DEPTHWISE_CONV_STREAM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CDCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdcs assertion failed: same-cycle implication");
// next-cycle implication
`define CDCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdcs assertion failed: next-cycle implication");
`else
`define CDCS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/cdcs_pkg.sv
// Shared types and constants of the causal depthwise convolution core
package cdcs_pkg;

   localparam int DataW       = 16;
   localparam int ChanW       = 9;
   localparam int TapW        = 4;
   localparam int FuncW       = 2;
   localparam int ProdW       = 2 * DataW;
   localparam int FracShift   = 14;
   localparam int RoundBias   = 8192;
   localparam int DefChannels = 512;
   localparam int DefTaps     = 15;

   typedef enum logic [FuncW-1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_WEIGHT = 2'd1,
      FUNC_BIAS   = 2'd2,
      FUNC_HIST   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic load_bias;
      logic mul_vld;
   } mac_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              saturated;
      logic [DataW-1:0]  result;
   } mac_sts_type;

endpackage

### design/cdcs_if.sv
// Request and response channel interfaces of the convolution core
interface cdcs_req_if;
   logic                          valid;
   logic                          ready;
   logic [cdcs_pkg::FuncW-1:0]    func;
   logic [cdcs_pkg::ChanW-1:0]    channel;
   logic [cdcs_pkg::TapW-1:0]     tap;
   logic signed [cdcs_pkg::DataW-1:0] value;

   modport source (output valid, func, channel, tap, value, input ready);
   modport sink   (input valid, func, channel, tap, value, output ready);
endinterface

interface cdcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cdcs_pkg::ChanW-1:0]    out_channel;
   logic signed [cdcs_pkg::DataW-1:0] out_value;
   logic                          saturated;

   modport source (output valid, out_channel, out_value, saturated, input ready);
   modport sink   (input valid, out_channel, out_value, saturated, output ready);
endinterface

### design/cdcs_mac.sv
// Multiply-accumulate datapath with Q2.14 rounding and saturation
module cdcs_mac #(
   parameter int TAPS = cdcs_pkg::DefTaps
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdcs_pkg::mac_ctl_type              ctl,
   input  logic signed [cdcs_pkg::DataW-1:0]  bias,
   input  logic signed [cdcs_pkg::DataW-1:0]  x,
   input  logic signed [cdcs_pkg::DataW-1:0]  w,
   output cdcs_pkg::mac_sts_type              sts
);

   localparam int AccW = cdcs_pkg::ProdW + $clog2(TAPS + 1);
   localparam logic signed [AccW-1:0] MaxQ = AccW'(32767);
   localparam logic signed [AccW-1:0] MinQ = -(AccW'(32768));

   logic signed [cdcs_pkg::ProdW-1:0] prod_ff;
   logic                              prod_vld_ff;
   logic signed [AccW-1:0]            acc_ff;
   logic signed [AccW-1:0]            rnd;
   logic signed [AccW-1:0]            shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_vld) begin
         prod_ff <= x * w;
      end
      // bias is aligned to the product scale
      if (ctl.load_bias) begin
         acc_ff <= AccW'(bias) <<< cdcs_pkg::FracShift;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + AccW'(prod_ff);
      end
   end

   // round half up, floor shift, clip to 16 bits
   always_comb begin
      rnd           = acc_ff + AccW'(cdcs_pkg::RoundBias);
      shifted       = rnd >>> cdcs_pkg::FracShift;
      sts.busy      = prod_vld_ff;
      sts.saturated = 1'b0;
      sts.result    = shifted[cdcs_pkg::DataW-1:0];
      if (shifted > MaxQ) begin
         sts.saturated = 1'b1;
         sts.result    = MaxQ[cdcs_pkg::DataW-1:0];
      end else if (shifted < MinQ) begin
         sts.saturated = 1'b1;
         sts.result    = MinQ[cdcs_pkg::DataW-1:0];
      end
   end

endmodule

### design/causal_depthwise_conv_stream_core.sv
// Sample transaction: taps issue one per cycle through the weight memory read port, and the
// next transaction is accepted only after the result has entered the response register.
// Load transactions (weight, bias, history) complete in the start state and produce no result.
// Reset: synchronous, active high; afterwards a clearing pass zeroes all CHANNELS*(TAPS-1)
// history memory entries, during which req_chan.ready stays low.
// Weight and bias memories are not cleared and are undefined until loaded.
`include "causal_depthwise_conv_stream_core_macros.svh"

module causal_depthwise_conv_stream_core #(
   parameter int CHANNELS = cdcs_pkg::DefChannels,
   parameter int TAPS     = cdcs_pkg::DefTaps
) (
   input logic        clock,
   input logic        reset,
   cdcs_req_if.sink   req_chan,
   cdcs_rsp_if.source rsp_chan
);

   // memory geometry
   localparam int Hist   = TAPS - 1;
   localparam int WDepth = CHANNELS * TAPS;
   localparam int HDepth = CHANNELS * Hist;
   localparam int WAW    = (WDepth > 1) ? $clog2(WDepth) : 1;
   localparam int HAW    = (HDepth > 1) ? $clog2(HDepth) : 1;
   localparam int BAW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int KW     = $clog2(TAPS);
   localparam int DW     = cdcs_pkg::DataW;

   // control state
   cdcs_pkg::state_type state_ff, state_in;
   logic [HAW-1:0]      clr_ff, clr_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                rd_vld_ff;
   logic [KW-1:0]       rd_k_ff;

   // captured transaction
   cdcs_pkg::func_type            func_ff;
   logic [cdcs_pkg::ChanW-1:0]    ch_ff;
   logic [cdcs_pkg::TapW-1:0]     tap_ff;
   logic signed [DW-1:0]          val_ff;
   logic [WAW-1:0]                wbase_ff;
   logic [HAW-1:0]                hbase_ff;

   // memories
   logic [DW-1:0] wmem [WDepth];
   logic [DW-1:0] bmem [CHANNELS];
   logic [DW-1:0] hmem [HDepth];
   logic [DW-1:0] w_rdata_ff, b_rdata_ff, h_rdata_ff;

   logic           w_we, w_re, b_we, b_re, h_we, h_re;
   logic [WAW-1:0] w_waddr, w_raddr;
   logic [BAW-1:0] b_waddr, b_raddr;
   logic [HAW-1:0] h_waddr, h_raddr;
   logic [DW-1:0]  w_wdata, b_wdata, h_wdata;

   // result register
   logic                       rsp_valid_ff;
   logic [cdcs_pkg::ChanW-1:0] out_ch_ff;
   logic signed [DW-1:0]       out_val_ff;
   logic                       sat_ff;

   logic                  req_accept;
   logic                  in_range;
   logic                  clr_last;
   logic                  fin;
   logic                  last_tap;
   cdcs_pkg::mac_ctl_type mac_ctl;
   cdcs_pkg::mac_sts_type mac_sts;
   logic signed [DW-1:0]  mac_x;

   assign req_chan.ready = (state_ff == cdcs_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_range       = (32'(ch_ff) < CHANNELS);
   assign clr_last       = (clr_ff == HAW'(HDepth - 1));
   assign last_tap       = (rd_k_ff == KW'(TAPS - 1));

   // finish once the MAC pipeline is empty and the result slot is free
   assign fin = (state_ff == cdcs_pkg::ST_DRAIN) && !rd_vld_ff && !mac_sts.busy
                && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdcs_pkg::ST_CLEAR: begin
            if (clr_last) state_in = cdcs_pkg::ST_IDLE;
         end
         cdcs_pkg::ST_IDLE: begin
            if (req_accept) state_in = cdcs_pkg::ST_START;
         end
         cdcs_pkg::ST_START: begin
            // loads and out-of-range channels complete here
            if (in_range && func_ff == cdcs_pkg::FUNC_SAMPLE) state_in = cdcs_pkg::ST_RUN;
            else state_in = cdcs_pkg::ST_IDLE;
         end
         cdcs_pkg::ST_RUN: begin
            if (k_ff == KW'(TAPS - 1)) state_in = cdcs_pkg::ST_DRAIN;
         end
         cdcs_pkg::ST_DRAIN: begin
            if (fin) state_in = cdcs_pkg::ST_IDLE;
         end
         default: state_in = cdcs_pkg::ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      w_we    = 1'b0;
      w_waddr = '0;
      w_wdata = val_ff;
      w_re    = 1'b0;
      w_raddr = '0;
      b_we    = 1'b0;
      b_waddr = '0;
      b_wdata = val_ff;
      b_re    = 1'b0;
      b_raddr = '0;
      h_we    = 1'b0;
      h_waddr = '0;
      h_wdata = val_ff;
      h_re    = 1'b0;
      h_raddr = '0;
      clr_in  = clr_ff;
      k_in    = k_ff;
      mac_ctl.load_bias = 1'b0;
      mac_ctl.mul_vld   = rd_vld_ff;

      unique case (state_ff)
         cdcs_pkg::ST_CLEAR: begin
            // zero one history entry per cycle
            h_we    = 1'b1;
            h_waddr = clr_ff;
            h_wdata = '0;
            clr_in  = clr_ff + 1'b1;
         end
         cdcs_pkg::ST_IDLE: begin
            clr_in = '0;
         end
         cdcs_pkg::ST_START: begin
            k_in = '0;
            if (in_range) begin
               unique case (func_ff)
                  cdcs_pkg::FUNC_WEIGHT: begin
                     w_we    = (32'(tap_ff) < TAPS);
                     w_waddr = WAW'(32'(ch_ff) * TAPS + 32'(tap_ff));
                  end
                  cdcs_pkg::FUNC_BIAS: begin
                     b_we    = 1'b1;
                     b_waddr = BAW'(ch_ff);
                  end
                  cdcs_pkg::FUNC_HIST: begin
                     h_we    = (32'(tap_ff) < Hist);
                     h_waddr = HAW'(32'(ch_ff) * Hist + 32'(tap_ff));
                  end
                  cdcs_pkg::FUNC_SAMPLE: begin
                     b_re    = 1'b1;
                     b_raddr = BAW'(ch_ff);
                  end
                  default: ;
               endcase
            end
         end
         cdcs_pkg::ST_RUN: begin
            // issue one tap per cycle; the last tap multiplies the new sample
            w_re    = 1'b1;
            w_raddr = wbase_ff + WAW'(k_ff);
            h_re    = (32'(k_ff) < Hist);
            h_raddr = hbase_ff + HAW'(k_ff);
            k_in    = k_ff + 1'b1;
            mac_ctl.load_bias = (k_ff == '0);
         end
         cdcs_pkg::ST_DRAIN: ;
         default: ;
      endcase

      // write back the shifted history behind the reads: slot k-1 takes slot k,
      // the newest slot takes the sample
      if (rd_vld_ff && rd_k_ff != '0) begin
         h_we    = 1'b1;
         h_waddr = hbase_ff + HAW'(rd_k_ff) - 1'b1;
         h_wdata = last_tap ? val_ff : h_rdata_ff;
      end
   end

   assign mac_x = last_tap ? val_ff : $signed(h_rdata_ff);

   cdcs_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .bias  ($signed(b_rdata_ff)),
      .x     (mac_x),
      .w     ($signed(w_rdata_ff)),
      .sts   (mac_sts)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdcs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         k_ff      <= k_in;
         rd_vld_ff <= (state_ff == cdcs_pkg::ST_RUN);
         // hold the result until taken; a new one may replace it in the same cycle
         if (fin) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= cdcs_pkg::func_type'(req_chan.func);
         ch_ff   <= req_chan.channel;
         tap_ff  <= req_chan.tap;
         val_ff  <= req_chan.value;
      end
      if (state_ff == cdcs_pkg::ST_START) begin
         wbase_ff <= WAW'(32'(ch_ff) * TAPS);
         hbase_ff <= HAW'(32'(ch_ff) * Hist);
      end
      rd_k_ff <= k_ff;
      if (fin) begin
         out_ch_ff  <= ch_ff;
         out_val_ff <= $signed(mac_sts.result);
         sat_ff     <= mac_sts.saturated;
      end
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (w_we) wmem[w_waddr] <= w_wdata;
      if (w_re) w_rdata_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) bmem[b_waddr] <= b_wdata;
      if (b_re) b_rdata_ff <= bmem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (h_we) hmem[h_waddr] <= h_wdata;
      if (h_re) h_rdata_ff <= hmem[h_raddr];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = out_ch_ff;
   assign rsp_chan.out_value   = out_val_ff;
   assign rsp_chan.saturated   = sat_ff;

   // ---------------------------------------------------------------- assertions
   `CDCS_ASSERT_IMPL(a_clear_no_rsp, clock, reset, state_ff == cdcs_pkg::ST_CLEAR, !rsp_valid_ff)
   `CDCS_ASSERT_IMPL(a_pipe_in_item, clock, reset, rd_vld_ff || mac_sts.busy, state_ff == cdcs_pkg::ST_RUN || state_ff == cdcs_pkg::ST_DRAIN)
   `CDCS_ASSERT_NEXT(a_fin_shows_rsp, clock, reset, fin, rsp_valid_ff)
   `CDCS_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == cdcs_pkg::ST_START)

endmodule

### sim/cdcs_conv_checker.sv
// Checker for the depthwise convolution core: follows the loads, predicts outputs, compares
module cdcs_conv_checker #(
   parameter int CHANNELS = cdcs_pkg::DefChannels,
   parameter int TAPS     = cdcs_pkg::DefTaps
) (
   input  logic clock,
   input  logic reset,
   cdcs_req_if  req_mon,
   cdcs_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import cdcs_pkg::*;

   localparam int HistDepth = TAPS - 1;
   localparam longint OutMax = 32767;
   localparam longint OutMin = -32768;

   typedef struct {
      logic [ChanW-1:0]        chan;
      logic signed [DataW-1:0] value;
      logic                    sat;
   } conv_out_t;

   // unwritten weights and biases read as zero; stimulus never samples them
   logic signed [DataW-1:0] weight_mem  [CHANNELS*TAPS]      = '{default: '0};
   logic signed [DataW-1:0] bias_mem    [CHANNELS]           = '{default: '0};
   logic signed [DataW-1:0] history_mem [CHANNELS*HistDepth] = '{default: '0};

   conv_out_t expected_outputs [$];
   int fail_count    = 0;
   int pending_count = 0;

   assign mismatches  = fail_count;
   assign outstanding = pending_count;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // apply one request transaction to the local copy and queue its output, if any
   task automatic predict_conv_output(input func_type fn, input int ch, input int tp,
                                      input logic signed [DataW-1:0] val);
      longint    acc;
      longint    rounded;
      conv_out_t res;
      int        k;
      if (ch < CHANNELS) begin
         case (fn)
            FUNC_WEIGHT: if (tp < TAPS) weight_mem[ch*TAPS + tp] = val;
            FUNC_BIAS:   bias_mem[ch] = val;
            FUNC_HIST:   if (tp < HistDepth) history_mem[ch*HistDepth + tp] = val;
            default: begin
               acc = longint'(bias_mem[ch]) <<< FracShift;
               for (k = 0; k < HistDepth; k++)
                  acc += longint'(history_mem[ch*HistDepth + k])
                         * longint'(weight_mem[ch*TAPS + k]);
               acc += longint'(val) * longint'(weight_mem[ch*TAPS + TAPS - 1]);
               rounded = (acc + RoundBias) >>> FracShift;
               res.sat = 1'b1;
               if (rounded > OutMax)      rounded = OutMax;
               else if (rounded < OutMin) rounded = OutMin;
               else                       res.sat = 1'b0;
               res.chan  = ch[ChanW-1:0];
               res.value = rounded[DataW-1:0];
               expected_outputs.push_back(res);
               for (k = 0; k < HistDepth - 1; k++)
                  history_mem[ch*HistDepth + k] = history_mem[ch*HistDepth + k + 1];
               history_mem[ch*HistDepth + HistDepth - 1] = val;
            end
         endcase
      end
   endtask

   task automatic check_output;
      conv_out_t want;
      if (expected_outputs.size() == 0) begin
         report_mismatch($sformatf("output on channel %0d with none expected",
                                   rsp_mon.out_channel));
      end else begin
         want = expected_outputs.pop_front();
         if (rsp_mon.out_channel !== want.chan)
            report_mismatch($sformatf("out_channel %0d, expected %0d",
                                      rsp_mon.out_channel, want.chan));
         if (rsp_mon.out_value !== want.value)
            report_mismatch($sformatf("out_value %0d on channel %0d, expected %0d",
                                      rsp_mon.out_value, want.chan, want.value));
         if (rsp_mon.saturated !== want.sat)
            report_mismatch($sformatf("saturated %b on channel %0d, expected %b",
                                      rsp_mon.saturated, want.chan, want.sat));
      end
   endtask

   always @(posedge clock) begin : watch
      int k;
      if (reset) begin
         for (k = 0; k < CHANNELS*HistDepth; k++) history_mem[k] = '0;
         expected_outputs.delete();
      end else begin
         // outputs first: an output at this edge belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) check_output();
         if (req_mon.valid && req_mon.ready)
            predict_conv_output(func_type'(req_mon.func), int'(req_mon.channel),
                                int'(req_mon.tap), req_mon.value);
      end
      pending_count = expected_outputs.size();
   end

endmodule

### sim/tb.sv
// Testbench top for the causal depthwise convolution core: stimulus, stalls and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdcs_pkg::*;

   localparam int CHANNELS    = DefChannels;
   localparam int TAPS        = DefTaps;
   localparam int ITEM_TARGET = 950;
   localparam int CALM_ITEMS  = 150;
   localparam int POOL        = 8;
   // the clearing pass after reset is the longest stretch with no transaction
   localparam int IDLE_LIMIT  = 4 * CHANNELS * (TAPS - 1) + 1000;
   localparam int SETTLE      = 2 * (TAPS + 5);

   logic clock;
   logic reset;
   logic calm;
   int   mismatches;
   int   outstanding;

   cdcs_req_if req_chan ();
   cdcs_rsp_if rsp_chan ();

   causal_depthwise_conv_stream_core #(
      .CHANNELS(CHANNELS),
      .TAPS    (TAPS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   cdcs_conv_checker #(
      .CHANNELS(CHANNELS),
      .TAPS    (TAPS)
   ) conv_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stimulus-side bookkeeping: which weights and biases hold a value, so that
   // samples only go to fully loaded channels.
   bit weight_seen [CHANNELS][TAPS];
   bit bias_seen   [CHANNELS];
   int useful_items = 0;
   int gap_odds     = 4;

   function automatic bit chan_armed(input int ch);
      int k;
      if (!bias_seen[ch]) return 1'b0;
      for (k = 0; k < TAPS; k++)
         if (!weight_seen[ch][k]) return 1'b0;
      return 1'b1;
   endfunction

   // Random Q value: mostly within +-span, sometimes full range or an extreme.
   function automatic logic [DataW-1:0] rand_q(input int span);
      int v;
      case ($urandom_range(0, 6))
         0:       v = $urandom_range(0, 65535) - 32768;
         1:       v = $urandom_range(0, 1) ? 32767 : -32768;
         2:       v = $urandom_range(0, 1) - 1;
         default: v = $urandom_range(0, 2 * span - 1) - span;
      endcase
      return v[DataW-1:0];
   endfunction

   // Drive one request transaction. Call at a falling edge; returns at the
   // falling edge after acceptance with valid still high, so that a following
   // transaction keeps valid up without a second assignment in that step.
   task automatic put_item(input func_type fn, input int ch, input int tp,
                           input logic [DataW-1:0] val);
      int gap;
      gap = 0;
      if (useful_items % 50 == 0) gap_odds = $urandom_range(0, 2) * 3;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= fn;
      req_chan.channel <= ch[ChanW-1:0];
      req_chan.tap     <= tp[TapW-1:0];
      req_chan.value   <= val;
      do @(posedge clock); while (!req_chan.ready);
      if (fn == FUNC_WEIGHT && tp < TAPS) weight_seen[ch][tp] = 1'b1;
      if (fn == FUNC_BIAS) bias_seen[ch] = 1'b1;
      // count only transactions that change something
      if (!((fn == FUNC_WEIGHT && tp >= TAPS) || (fn == FUNC_HIST && tp >= TAPS - 1)))
         useful_items++;
      @(negedge clock);
   endtask

   // Response stall pattern: a series of stretches, each either free of stalls or with
   // stall bursts at 1 in 3 or 1 in 6 odds.
   int stall_left   = 0;
   int stall_odds   = 0;
   int stretch_left = 0;

   always @(negedge clock) begin
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(20, 80);
         stall_odds   = $urandom_range(0, 2) * 3;
      end
      stretch_left--;
      if (stall_left == 0 && !calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
         stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int pool [POOL];
      int p;
      int k;
      int ch;
      int pick;

      // hold every input at a known value from time zero
      reset            = 1'b1;
      calm             = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_SAMPLE;
      req_chan.channel = '0;
      req_chan.tap     = '0;
      req_chan.value   = '0;
      rsp_chan.ready   = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: top channel with every weight and the bias at full scale.
      for (k = 0; k < TAPS; k++) put_item(FUNC_WEIGHT, CHANNELS - 1, k, 16'h7fff);
      put_item(FUNC_BIAS, CHANNELS - 1, 0, 16'h7fff);
      // out-of-range weight index and history slots: must be dropped
      put_item(FUNC_WEIGHT, CHANNELS - 1, TAPS, 16'h8000);
      put_item(FUNC_HIST, CHANNELS - 1, TAPS - 1, 16'h8000);
      put_item(FUNC_HIST, CHANNELS - 1, 15, 16'h7fff);
      // positive clip, then a written history slot pushing toward negative clip
      put_item(FUNC_SAMPLE, CHANNELS - 1, 15, 16'h7fff);
      put_item(FUNC_HIST, CHANNELS - 1, 0, 16'h8000);
      put_item(FUNC_SAMPLE, CHANNELS - 1, 0, 16'h8000);
      // most negative bias and newest-sample weight
      put_item(FUNC_BIAS, CHANNELS - 1, 7, 16'h8000);
      put_item(FUNC_WEIGHT, CHANNELS - 1, TAPS - 1, 16'h8000);
      put_item(FUNC_SAMPLE, CHANNELS - 1, 5, 16'h7fff);
      put_item(FUNC_SAMPLE, CHANNELS - 1, 10, 16'h0000);

      // Arm a pool of channels, the lowest and highest among them.
      pool[0] = 0;
      pool[1] = CHANNELS - 1;
      for (p = 2; p < POOL; p++) pool[p] = $urandom_range(1, CHANNELS - 2);
      for (p = 0; p < POOL; p++) begin
         if (!chan_armed(pool[p])) begin
            for (k = 0; k < TAPS; k++) put_item(FUNC_WEIGHT, pool[p], k, rand_q(1024));
            put_item(FUNC_BIAS, pool[p], $urandom_range(0, 15), rand_q(8192));
         end
      end

      // Random: mostly samples on armed channels mixed with reloads, plus
      // scattered loads to any channel as noise. Drop idling near the end.
      while (useful_items < ITEM_TARGET) begin
         calm = (useful_items >= ITEM_TARGET - CALM_ITEMS);
         pick = $urandom_range(0, 99);
         ch   = pool[$urandom_range(0, POOL - 1)];
         if (pick < 55 && chan_armed(ch))
            put_item(FUNC_SAMPLE, ch, $urandom_range(0, 15), rand_q(8192));
         else if (pick < 70)
            put_item(FUNC_WEIGHT, ch, $urandom_range(0, 15), rand_q(1024));
         else if (pick < 77)
            put_item(FUNC_BIAS, ch, $urandom_range(0, 15), rand_q(8192));
         else if (pick < 90)
            put_item(FUNC_HIST, ch, $urandom_range(0, 15), rand_q(8192));
         else
            put_item(func_type'($urandom_range(1, 3)), $urandom_range(0, CHANNELS - 1),
                     $urandom_range(0, 15), rand_q(32768));
      end
      req_chan.valid <= 1'b0;

      // Drain: wait for every predicted output, then a little longer to catch extras.
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### causal_depthwise_conv_stream_core.f
+incdir+design
design/cdcs_pkg.sv
design/cdcs_if.sv
design/cdcs_mac.sv
design/causal_depthwise_conv_stream_core.sv
sim/cdcs_conv_checker.sv
sim/tb.sv
